// ===== hdl/go_back_n_packet_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// go-back-n receiver assertion macros
// property forms used by the receiver back end
// ----------------------------------------------------------------------------
`ifndef GO_BACK_N_PACKET_RECEIVER_ASSERT_SVH
`define GO_BACK_N_PACKET_RECEIVER_ASSERT_SVH

// same-cycle implication, idle during reset
`define GBNR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define GBNR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gbnr_pkg.sv =====
// ----------------------------------------------------------------------------
// gbnr_pkg
// types and constants shared by the go-back-n receiver modules
// ----------------------------------------------------------------------------
package gbnr_pkg;

  // payload size of a full packet in bytes
  localparam int PAYLOAD_BYTES = 12000;

  // widths of the stream fields
  localparam int WORD_W  = 16;
  localparam int COUNT_W = 13;
  localparam int DLEN_W  = 14;
  localparam int SEQ_W   = 16;

  // word offsets of the header fields
  localparam logic [COUNT_W-1:0] WORD_TYPE  = 13'd5;
  localparam logic [COUNT_W-1:0] WORD_FLAGS = 13'd6;
  localparam logic [COUNT_W-1:0] WORD_SEQ   = 13'd10;
  localparam logic [COUNT_W-1:0] WORD_LEN   = 13'd12;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'd8191;

  // checksum of an intact packet and the packet type that ends a transfer
  localparam logic [WORD_W-1:0] SUM_GOOD = 16'hffff;
  localparam logic [7:0]        TYPE_FIN = 8'd2;

  // largest length the result field carries
  localparam logic [WORD_W-1:0] DLEN_MAX  = 16'd16383;
  localparam logic [WORD_W-1:0] PAYLOAD_W = 16'(PAYLOAD_BYTES);

  // queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // decision codes
  typedef enum logic [1:0] {
    ACT_IGNORE = 2'd0,
    ACT_REACK  = 2'd1,
    ACT_ACCEPT = 2'd2,
    ACT_FINISH = 2'd3
  } action_t;

  // classified packet handed from the front to the back
  typedef struct packed {
    logic              good;
    logic              fin_type;
    logic [SEQ_W-1:0]  seq;
    logic [DLEN_W-1:0] dlen;
  } pkt_summary_t;

endpackage

// ===== hdl/gbnr_front.sv =====
// ----------------------------------------------------------------------------
// gbnr_front
// folds the checksum, captures header fields and classifies each packet
// ----------------------------------------------------------------------------
module gbnr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         word_accept,
  input  logic [gbnr_pkg::WORD_W-1:0]  word,
  input  logic                         last,
  output logic                         push,
  output gbnr_pkg::pkt_summary_t       summary
);
  import gbnr_pkg::*;

  logic [WORD_W-1:0]  running_sum;
  logic [COUNT_W-1:0] word_count;
  logic [7:0]         pkt_type;
  logic [7:0]         final_flag;
  logic [7:0]         valid_mark;
  logic [SEQ_W-1:0]   seq_number;
  logic [WORD_W-1:0]  len_field;

  logic [WORD_W:0]    sum_wide;
  logic [WORD_W-1:0]  running_sum_next;
  logic [7:0]         pkt_type_next;
  logic [7:0]         final_flag_next;
  logic [7:0]         valid_mark_next;
  logic [SEQ_W-1:0]   seq_number_next;
  logic [WORD_W-1:0]  len_field_next;
  logic [WORD_W-1:0]  len_capped;
  logic [WORD_W-1:0]  dlen_wide;

  // ones' complement add with end-around carry
  always_comb begin
    sum_wide = {1'b0, running_sum} + {1'b0, word};
    running_sum_next = sum_wide[WORD_W] ? (sum_wide[WORD_W-1:0] + 16'd1)
                                        : sum_wide[WORD_W-1:0];
  end

  // header capture including the current word
  always_comb begin
    pkt_type_next   = pkt_type;
    final_flag_next = final_flag;
    valid_mark_next = valid_mark;
    seq_number_next = seq_number;
    len_field_next  = len_field;
    case (word_count)
      WORD_TYPE: pkt_type_next = word[15:8];
      WORD_FLAGS: begin
        final_flag_next = word[7:0];
        valid_mark_next = word[15:8];
      end
      WORD_SEQ: seq_number_next = word;
      WORD_LEN: len_field_next = word;
      default: ;
    endcase
  end

  // length to deliver if this packet is accepted
  always_comb begin
    len_capped = (len_field_next > PAYLOAD_W) ? PAYLOAD_W : len_field_next;
    dlen_wide  = (final_flag_next != 8'd0) ? len_capped : PAYLOAD_W;
    if (dlen_wide > DLEN_MAX) begin
      dlen_wide = DLEN_MAX;
    end
  end

  // packet summary on the last word
  always_comb begin
    push             = word_accept && last;
    summary.good     = (valid_mark_next != 8'd0) && (running_sum_next == SUM_GOOD);
    summary.fin_type = (pkt_type_next == TYPE_FIN);
    summary.seq      = seq_number_next;
    summary.dlen     = dlen_wide[DLEN_W-1:0];
  end

  // per-packet state, cleared after every last word
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      word_count  <= '0;
      pkt_type    <= '0;
      final_flag  <= '0;
      valid_mark  <= '0;
      seq_number  <= '0;
      len_field   <= '0;
    end else if (word_accept) begin
      if (last) begin
        running_sum <= '0;
        word_count  <= '0;
        pkt_type    <= '0;
        final_flag  <= '0;
        valid_mark  <= '0;
        seq_number  <= '0;
        len_field   <= '0;
      end else begin
        running_sum <= running_sum_next;
        pkt_type    <= pkt_type_next;
        final_flag  <= final_flag_next;
        valid_mark  <= valid_mark_next;
        seq_number  <= seq_number_next;
        len_field   <= len_field_next;
        if (word_count != COUNT_MAX) begin
          word_count <= word_count + 13'd1;
        end
      end
    end
  end

endmodule

// ===== hdl/gbnr_queue.sv =====
// ----------------------------------------------------------------------------
// gbnr_queue
// short queue of packet summaries between the front and the back
// ----------------------------------------------------------------------------
module gbnr_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  gbnr_pkg::pkt_summary_t  push_data,
  input  logic                    pop,
  output gbnr_pkg::pkt_summary_t  head,
  output logic                    full,
  output logic                    empty
);
  import gbnr_pkg::*;

  pkt_summary_t      entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  // status and head entry
  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/gbnr_back.sv =====
// ----------------------------------------------------------------------------
// gbnr_back
// go-back-n decision, ack tracking and result register
// ----------------------------------------------------------------------------
module gbnr_back (
  input  logic                          clk,
  input  logic                          rst,
  input  gbnr_pkg::pkt_summary_t        head,
  input  logic                          empty,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output gbnr_pkg::action_t             out_action,
  output logic [gbnr_pkg::SEQ_W-1:0]    out_ack,
  output logic [gbnr_pkg::DLEN_W-1:0]   out_dlen
);
  import gbnr_pkg::*;
  `include "go_back_n_packet_receiver_assert.svh"

  logic [SEQ_W-1:0]  expected_ack;
  logic              finished;
  action_t           action;
  logic [SEQ_W-1:0]  expected_ack_next;
  logic [DLEN_W-1:0] dlen;
  logic [SEQ_W:0]    ack_plus_one;

  // take a summary when the result register is free or drains now
  assign pop = !empty && (!out_valid || out_ready);

  // decision on the head summary
  always_comb begin
    ack_plus_one      = {1'b0, expected_ack} + 17'd1;
    action            = ACT_IGNORE;
    expected_ack_next = expected_ack;
    dlen              = '0;
    if (finished) begin
      action = ACT_IGNORE;
    end else if (head.good && head.fin_type && (expected_ack != '0)) begin
      action = ACT_FINISH;
    end else if (head.good && (head.seq != '0) && (expected_ack >= head.seq)) begin
      action = ACT_REACK;
    end else if (head.good && ({1'b0, head.seq} == ack_plus_one)) begin
      action            = ACT_ACCEPT;
      expected_ack_next = head.seq;
      dlen              = head.dlen;
    end
  end

  // transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_ack <= '0;
      finished     <= 1'b0;
    end else if (pop) begin
      expected_ack <= expected_ack_next;
      if (action == ACT_FINISH) begin
        finished <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_action <= action;
      out_ack    <= expected_ack_next;
      out_dlen   <= dlen;
    end
  end

  // checks
  `GBNR_ASSERT_NEXT(a_finished_sticks, finished, finished, "finished flag cleared")
  `GBNR_ASSERT_NEXT(a_ack_moves_on_accept, !(pop && (action == ACT_ACCEPT)),
                    $stable(expected_ack), "ack changed without in-order accept")
  `GBNR_ASSERT_NEXT(a_ignore_after_finish, pop && finished,
                    out_action == ACT_IGNORE, "packet acted on after finish")
  `GBNR_ASSERT_NOW(a_dlen_only_on_accept, out_valid && (out_action != ACT_ACCEPT),
                   out_dlen == '0, "delivery length outside accept")

endmodule

// ===== hdl/go_back_n_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// go_back_n_packet_receiver
// go-back-n receiver with ones' complement checksum and ack tracking
// ----------------------------------------------------------------------------
// Packet words enter on the s_ channel, one 16-bit little-endian word per
// request, with s_tlast high on the final word of a packet. Each packet gives
// exactly one decision request on the m_ channel: action, cumulative ack and
// the number of payload bytes to commit.
// The input takes one word per cycle while s_tready is high. A packet summary
// is queued at its last word and passes from the summary queue into the
// decision register. Decisions leave at one per cycle while m_tready is high,
// and the back end, with its single ack register, decides one packet per cycle.
// When m_tready is low, finished decisions wait in the result register and a
// four-entry summary queue; the input keeps taking words until that queue is
// full, then s_tready drops until a decision drains.
// Reset clears the checksum, header captures, expected ack and finished flag;
// the first packet after reset starts at word zero. After a finish decision
// every later packet is ignored until reset.
// ----------------------------------------------------------------------------
module go_back_n_packet_receiver (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] packet_word
  input  logic        s_tlast,   // last_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [1:0] action, [17:2] ack_value, [31:18] deliver_len
);
  import gbnr_pkg::*;

  logic              word_accept;
  logic              push;
  pkt_summary_t      summary;
  pkt_summary_t      head;
  logic              pop;
  logic              full;
  logic              empty;
  action_t           out_action;
  logic [SEQ_W-1:0]  out_ack;
  logic [DLEN_W-1:0] out_dlen;

  // input request handshake
  assign s_tready    = !full;
  assign word_accept = s_tvalid && s_tready;

  gbnr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .word_accept (word_accept),
    .word        (s_tdata),
    .last        (s_tlast),
    .push        (push),
    .summary     (summary)
  );

  gbnr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (summary),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  gbnr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_action (out_action),
    .out_ack    (out_ack),
    .out_dlen   (out_dlen)
  );

  // output packing
  assign m_tdata = {out_dlen, out_ack, out_action};

endmodule
